[hdl/adpe_pkg.sv]
// Shared types, codes and opcode table for the data-processing encoder.
package adpe_pkg;

   localparam int unsigned FUNC_W   = 4;
   localparam int unsigned REG_W    = 4;
   localparam int unsigned FORM_W   = 2;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned AMOUNT_W = 5;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned OPS_W    = 5;

   localparam logic [3:0]         COND_ALWAYS   = 4'hE;
   localparam logic [WORD_W-1:0]  IMM8_LIMIT    = 32'd255;
   localparam logic [COUNT_W-1:0] ROT_STEPS_MAX = 4'd15;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_AND = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_EOR = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_RSB = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_ADD = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_ORR = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_MOV = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_TST = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_TEQ = 4'd8;
   localparam logic [FUNC_W-1:0] FUNC_CMP = 4'd9;

   // operand 2 forms
   localparam logic [FORM_W-1:0] FORM_IMM       = 2'd0;
   localparam logic [FORM_W-1:0] FORM_REG       = 2'd1;
   localparam logic [FORM_W-1:0] FORM_SHIFT_IMM = 2'd2;
   localparam logic [FORM_W-1:0] FORM_SHIFT_REG = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request beat
      logic step;    // one rotate-right-by-two
      logic finish;  // write result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_rot;  // request needs the immediate search
      logic cont;      // search loop continues
   } sts_type;

   // opcode + S bits (instruction bits 24:20)
   function automatic logic [OPS_W-1:0] op_bits(input logic [FUNC_W-1:0] func);
      logic [OPS_W-1:0] r;
      unique case (func)
         FUNC_AND: r = 5'd0;
         FUNC_EOR: r = 5'd2;
         FUNC_SUB: r = 5'd4;
         FUNC_RSB: r = 5'd6;
         FUNC_ADD: r = 5'd8;
         FUNC_ORR: r = 5'd24;
         FUNC_MOV: r = 5'd26;
         FUNC_TST: r = 5'd17;
         FUNC_TEQ: r = 5'd19;
         FUNC_CMP: r = 5'd21;
         default:  r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] ror_two(input logic [WORD_W-1:0] v);
      return {v[1:0], v[WORD_W-1:2]};
   endfunction

endpackage

[hdl/adpe_dpath.sv]
// Datapath: request capture, shared rotator, result register.
module adpe_dpath (
   input  logic                           clock,
   input  adpe_pkg::cmd_type              cmd,
   output adpe_pkg::sts_type              sts,
   input  logic [adpe_pkg::FUNC_W-1:0]    req_func,
   input  logic [adpe_pkg::REG_W-1:0]     req_dest_reg,
   input  logic [adpe_pkg::REG_W-1:0]     req_first_reg,
   input  logic [adpe_pkg::FORM_W-1:0]    req_operand_form,
   input  logic [adpe_pkg::WORD_W-1:0]    req_imm_value,
   input  logic [adpe_pkg::REG_W-1:0]     req_second_reg,
   input  logic [adpe_pkg::KIND_W-1:0]    req_shift_kind,
   input  logic [adpe_pkg::AMOUNT_W-1:0]  req_shift_amount,
   input  logic [adpe_pkg::REG_W-1:0]     req_shift_reg,
   output logic [adpe_pkg::WORD_W-1:0]    rsp_instruction,
   output logic                           rsp_not_encodable
);
   import adpe_pkg::*;

   logic [WORD_W-1:0]  base_ff, base_in;
   logic [WORD_W-1:0]  v_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               imm_mode_ff, bad_func_ff;
   logic [WORD_W-1:0]  instr_ff, instr_in;
   logic               ne_ff, ne_in;

   logic               is_cmp, bad_func, imm_mode;
   logic [REG_W-1:0]   rd, rn;
   logic [11:0]        low_field;
   logic [WORD_W-1:0]  v_rot;
   logic               fail;

   assign v_rot = ror_two(v_ff);

   always_comb begin
      bad_func = req_func > FUNC_CMP;
      is_cmp   = req_func >= FUNC_TST;
      imm_mode = req_operand_form == FORM_IMM;
      rd       = is_cmp ? '0 : req_dest_reg;
      rn       = (req_func == FUNC_MOV) ? '0 : req_first_reg;
      priority if (imm_mode) begin
         low_field = '0;
      end else if (is_cmp || req_operand_form == FORM_REG) begin
         low_field = {8'd0, req_second_reg};
      end else if (req_operand_form == FORM_SHIFT_IMM) begin
         low_field = {req_shift_amount, req_shift_kind, 1'b0, req_second_reg};
      end else begin
         low_field = {req_shift_reg, 1'b0, req_shift_kind, 1'b1, req_second_reg};
      end
      base_in = {COND_ALWAYS, 2'b00, imm_mode, op_bits(req_func), rn, rd, low_field};
      sts.need_rot = imm_mode && !bad_func && (req_imm_value > IMM8_LIMIT);
      sts.cont     = (count_ff != ROT_STEPS_MAX) &&
                     ((v_ff > IMM8_LIMIT) || (v_rot <= IMM8_LIMIT));
   end

   always_comb begin
      fail  = bad_func_ff || (imm_mode_ff && (v_ff > IMM8_LIMIT));
      ne_in = fail;
      if (fail) begin
         instr_in = '0;
      end else if (imm_mode_ff) begin
         // rotate field is (16 - count) mod 16
         instr_in = base_ff | {20'd0, COUNT_W'(4'd0 - count_ff), v_ff[7:0]};
      end else begin
         instr_in = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff     <= base_in;
         v_ff        <= req_imm_value;
         count_ff    <= '0;
         imm_mode_ff <= imm_mode;
         bad_func_ff <= bad_func;
      end else if (cmd.step) begin
         v_ff     <= v_rot;
         count_ff <= count_ff + 4'd1;
      end
      if (cmd.finish) begin
         instr_ff <= instr_in;
         ne_ff    <= ne_in;
      end
   end

   assign rsp_instruction   = instr_ff;
   assign rsp_not_encodable = ne_ff;

`ifndef NO_ASSERTIONS
   a_step_count: assert property (@(posedge clock)
      cmd.step |=> count_ff == $past(count_ff) + 4'd1)
      else $error("rotation count did not advance");
   a_load_clear: assert property (@(posedge clock)
      cmd.load |=> count_ff == '0)
      else $error("rotation count not cleared on load");
   a_fail_zero: assert property (@(posedge clock)
      cmd.finish && bad_func_ff |=> ne_ff && instr_ff == '0)
      else $error("bad operation did not give zero word with error flag");
`endif

endmodule

[hdl/adpe_ctrl.sv]
// Controller: sequences load, immediate search and result handoff.
module adpe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  adpe_pkg::sts_type sts,
   output adpe_pkg::cmd_type cmd
);
   import adpe_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ROTATE, ST_DONE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = sts.need_rot ? ST_ROTATE : ST_DONE;
         end
         ST_ROTATE: begin
            cmd.step = sts.cont;
            if (!sts.cont) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.finish)
      else $error("result register overwritten while held");
   a_step_cont: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> sts.cont)
      else $error("rotate step past loop end");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.finish}))
      else $error("more than one datapath command");
`endif

endmodule

[hdl/arm_data_processing_encoder.sv]
// Register forms and small immediates go from the request beat straight to the done state.
// Immediates above 255 first run the rotate search (one rotate-by-two per cycle,
// one shared rotator, at most 15 steps plus the exit check).
// One item in flight; a finished result waits in the output register while the next is taken.
// Reset: synchronous, active high; clears controller state and the result-valid flag.
// Top level: ARM data-processing instruction word encoder (condition always).
module arm_data_processing_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [adpe_pkg::FUNC_W-1:0]    req_func,
   input  logic [adpe_pkg::REG_W-1:0]     req_dest_reg,
   input  logic [adpe_pkg::REG_W-1:0]     req_first_reg,
   input  logic [adpe_pkg::FORM_W-1:0]    req_operand_form,
   input  logic [adpe_pkg::WORD_W-1:0]    req_imm_value,
   input  logic [adpe_pkg::REG_W-1:0]     req_second_reg,
   input  logic [adpe_pkg::KIND_W-1:0]    req_shift_kind,
   input  logic [adpe_pkg::AMOUNT_W-1:0]  req_shift_amount,
   input  logic [adpe_pkg::REG_W-1:0]     req_shift_reg,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [adpe_pkg::WORD_W-1:0]    rsp_instruction,
   output logic                           rsp_not_encodable
);
   import adpe_pkg::*;

   // command/status link between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // Controller: idle -> (rotate) -> done. Request beats are taken only in
   // idle; done waits for the result register to free up.
   adpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: builds the base word at load, runs the immediate search,
   // then assembles the final word (or zero plus error) into the result reg.
   adpe_dpath u_dpath (
      .clock             (clock),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_dest_reg      (req_dest_reg),
      .req_first_reg     (req_first_reg),
      .req_operand_form  (req_operand_form),
      .req_imm_value     (req_imm_value),
      .req_second_reg    (req_second_reg),
      .req_shift_kind    (req_shift_kind),
      .req_shift_amount  (req_shift_amount),
      .req_shift_reg     (req_shift_reg),
      .rsp_instruction   (rsp_instruction),
      .rsp_not_encodable (rsp_not_encodable)
   );

endmodule
